// ===== rtl/core/tsqm_pkg.sv =====
// Shared types and constants of the timestamp ordered queue merge.
`timescale 1ns / 1ps
package tsqm_pkg;
   localparam int NUM_QUEUES_DEF   = 4;
   localparam int QUEUE_DEPTH_DEF  = 8;
   localparam int PAYLOAD_BITS_DEF = 64;

   typedef enum logic [2:0] {
      KIND_RECORD  = 3'd0,
      KIND_EMPTIED = 3'd1,
      KIND_DONE    = 3'd2,
      KIND_ACCEPT  = 3'd3,
      KIND_REJECT  = 3'd4
   } kind_type;

   typedef struct packed {
      logic        is_drain;
      logic        idx_ok;
      logic [1:0]  queue;
      logic [63:0] time_stamp;
      logic [63:0] data;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [1:0]  queue;
      logic [63:0] time_stamp;
      logic [63:0] data;
   } res_type;
endpackage

// ===== rtl/core/tsqm_front.sv =====
// Front part: accepts requests, classifies them and queues them for the engine.
`timescale 1ns / 1ps
module tsqm_front import tsqm_pkg::*; #(
   parameter int NUM_QUEUES   = NUM_QUEUES_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [1:0]  req_queue_index,
   input  logic [63:0] req_time_stamp,
   input  logic [63:0] req_payload,
   output logic        item_valid,
   output item_type    item,
   input  logic        item_pop
);
   localparam logic [63:0] DataMask = {64{1'b1}} >> (64 - PAYLOAD_BITS);

   item_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   item_type   incoming;

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      incoming.is_drain   = req_cmd;
      incoming.idx_ok     = (3'(req_queue_index) < 3'(NUM_QUEUES));
      incoming.queue      = req_queue_index;
      incoming.time_stamp = req_time_stamp;
      incoming.data       = req_payload & DataMask;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= incoming;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (item_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(item_pop);
      end
   end
endmodule

// ===== rtl/core/tsqm_engine.sv =====
// Back part: queue storage, push and drain sequencer, and the result register.
`timescale 1ns / 1ps
module tsqm_engine import tsqm_pkg::*; #(
   parameter int NUM_QUEUES   = NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  item_type    item,
   output logic        item_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [1:0]  rsp_source_queue,
   output logic [63:0] rsp_record_time,
   output logic [63:0] rsp_record_data,
   output logic        rsp_last
);
   localparam int QW = $clog2(NUM_QUEUES);
   localparam int SW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
   localparam int AW = $clog2(ENTRIES);
   localparam int PW = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PUSH, ST_HEAD, ST_EVAL, ST_EMPTY, ST_FINAL, ST_FLUSH
   } state_type;

   state_type         state_ff;
   logic [SW-1:0]     head_ff [NUM_QUEUES];
   logic [FW-1:0]     fill_ff [NUM_QUEUES];
   logic [PW-1:0]     pending_ff;
   logic [63:0]       release_ff;
   logic [63:0]       next_ff;
   logic              have_next_ff;
   logic [QW-1:0]     qi_ff;
   res_type           hold_ff;
   logic              hold_valid_ff;
   res_type           out_ff;
   logic              out_valid_ff;
   logic              out_last_ff;

   logic [63:0]       time_mem [ENTRIES];
   logic [PAYLOAD_BITS-1:0] data_mem [ENTRIES];
   logic [63:0]       rd_time_ff;
   logic [PAYLOAD_BITS-1:0] rd_data_ff;

   logic [QW-1:0]     cq;
   logic [SW-1:0]     head_c;
   logic [FW-1:0]     fill_c;
   logic [FW:0]       slot_sum;
   logic [SW-1:0]     wslot;
   logic [SW-1:0]     head_next;
   logic [AW-1:0]     raddr;
   logic [AW-1:0]     waddr;
   logic              reject;
   logic              mem_we;
   logic              emit_req;
   res_type           emit_res;
   logic              out_free;
   logic              can_emit;
   logic              go;
   logic              last_queue;
   logic              rec_ok;
   logic              load_out;

   always_comb begin
      if (state_ff == ST_PUSH) begin
         cq = item.idx_ok ? item.queue[QW-1:0] : '0;
      end else begin
         cq = qi_ff;
      end
      head_c    = head_ff[cq];
      fill_c    = fill_ff[cq];
      slot_sum  = (FW+1)'(head_c) + (FW+1)'(fill_c);
      wslot     = (slot_sum >= (FW+1)'(QUEUE_DEPTH)) ?
                  SW'(slot_sum - (FW+1)'(QUEUE_DEPTH)) : SW'(slot_sum);
      head_next = (head_c == SW'(QUEUE_DEPTH - 1)) ? '0 : SW'(head_c + 1'b1);
      raddr     = AW'(AW'(cq) * AW'(QUEUE_DEPTH) + AW'(head_c));
      waddr     = AW'(AW'(cq) * AW'(QUEUE_DEPTH) + AW'(wslot));
      reject    = !item.idx_ok || (fill_c == FW'(QUEUE_DEPTH));
      rec_ok    = !(rd_time_ff > release_ff);
      last_queue = (qi_ff == QW'(NUM_QUEUES - 1));
      out_free  = !out_valid_ff || !rsp_stall;
      can_emit  = !hold_valid_ff || out_free;
      emit_req  = 1'b0;
      emit_res  = '{kind: KIND_DONE, queue: 2'd0, time_stamp: 64'd0, data: 64'd0};
      case (state_ff)
         ST_PUSH: begin
            emit_req       = 1'b1;
            emit_res.kind  = reject ? KIND_REJECT : KIND_ACCEPT;
            emit_res.queue = item.queue;
         end
         ST_EVAL: begin
            emit_req            = rec_ok;
            emit_res.kind       = KIND_RECORD;
            emit_res.queue      = 2'(qi_ff);
            emit_res.time_stamp = rd_time_ff;
            emit_res.data       = 64'(rd_data_ff);
         end
         ST_EMPTY: begin
            emit_req       = 1'b1;
            emit_res.kind  = KIND_EMPTIED;
            emit_res.queue = 2'(qi_ff);
         end
         ST_FINAL: begin
            emit_req = (pending_ff == '0);
         end
         default: begin
            emit_req = 1'b0;
         end
      endcase
      go       = !emit_req || can_emit;
      mem_we   = (state_ff == ST_PUSH) && go && !reject;
      item_pop = (state_ff == ST_FLUSH) && (!hold_valid_ff || out_free);
      load_out = hold_valid_ff && ((emit_req && go) || (state_ff == ST_FLUSH && out_free));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[waddr] <= item.time_stamp;
         data_mem[waddr] <= item.data[PAYLOAD_BITS-1:0];
      end
      rd_time_ff <= time_mem[raddr];
      rd_data_ff <= data_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         pending_ff    <= '0;
         release_ff    <= '0;
         have_next_ff  <= 1'b0;
         qi_ff         <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         out_last_ff   <= 1'b0;
      end else begin
         if (!rsp_stall && !load_out) out_valid_ff <= 1'b0;
         if (emit_req && go) begin
            if (hold_valid_ff) begin
               out_ff       <= hold_ff;
               out_last_ff  <= 1'b0;
               out_valid_ff <= 1'b1;
            end
            hold_ff       <= emit_res;
            hold_valid_ff <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  qi_ff        <= '0;
                  have_next_ff <= 1'b0;
                  state_ff     <= item.is_drain ? ST_HEAD : ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (go) begin
                  if (!reject) begin
                     if (fill_c == '0 && (item.time_stamp < release_ff || pending_ff == '0)) begin
                        release_ff <= item.time_stamp;
                     end
                     fill_ff[cq] <= fill_c + 1'b1;
                     pending_ff  <= pending_ff + 1'b1;
                  end
                  state_ff <= ST_FLUSH;
               end
            end
            ST_HEAD: begin
               if (fill_c != '0) begin
                  state_ff <= ST_EVAL;
               end else if (last_queue) begin
                  state_ff <= ST_FINAL;
               end else begin
                  qi_ff <= qi_ff + 1'b1;
               end
            end
            ST_EVAL: begin
               if (!rec_ok) begin
                  if (!have_next_ff || rd_time_ff < next_ff) begin
                     next_ff      <= rd_time_ff;
                     have_next_ff <= 1'b1;
                  end
                  if (last_queue) begin
                     state_ff <= ST_FINAL;
                  end else begin
                     qi_ff    <= qi_ff + 1'b1;
                     state_ff <= ST_HEAD;
                  end
               end else if (go) begin
                  head_ff[cq] <= head_next;
                  fill_ff[cq] <= fill_c - 1'b1;
                  pending_ff  <= pending_ff - 1'b1;
                  state_ff    <= (fill_c == FW'(1)) ? ST_EMPTY : ST_HEAD;
               end
            end
            ST_EMPTY: begin
               if (go) begin
                  if (last_queue) begin
                     state_ff <= ST_FINAL;
                  end else begin
                     qi_ff    <= qi_ff + 1'b1;
                     state_ff <= ST_HEAD;
                  end
               end
            end
            ST_FINAL: begin
               if (go) begin
                  if (pending_ff != '0 && have_next_ff) release_ff <= next_ff;
                  state_ff <= ST_FLUSH;
               end
            end
            ST_FLUSH: begin
               if (!hold_valid_ff) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  out_ff        <= hold_ff;
                  out_last_ff   <= 1'b1;
                  out_valid_ff  <= 1'b1;
                  hold_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_source_queue = out_ff.queue;
   assign rsp_record_time  = out_ff.time_stamp;
   assign rsp_record_data  = out_ff.data;
   assign rsp_last         = out_last_ff;

   logic [PW-1:0] fill_sum;
   always_comb begin
      fill_sum = '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         fill_sum = fill_sum + PW'(fill_ff[i]);
      end
   end

   a_pending_matches: assert property (@(posedge clock) disable iff (reset)
      pending_ff == fill_sum) else $error("Pending total differs from the queue fills.");
   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_valid_ff) else $error("A result is held while idle.");
   a_plain_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.kind != KIND_RECORD |-> out_ff.time_stamp == 64'd0)
      else $error("A non-record result carries a time.");
   a_pop_at_flush: assert property (@(posedge clock) disable iff (reset)
      item_pop |=> state_ff == ST_IDLE) else $error("Request retired outside flush.");
endmodule

// ===== rtl/core/timestamp_ordered_queue_merge.sv =====
// Top level of the timestamp ordered queue merge.
//
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_stall   cmd, queue_index, time_stamp, payload
// rsp      out        rsp_valid / rsp_stall   kind, source_queue, record_time,
//                                             record_data, last
//
// A push passes through the push and flush states to its result; a drain visits each queue
// through the head and evaluate states, reading each record by the registered read of the
// queue store, and then ends in the final and flush states.
// A two-entry request queue in front lets new requests enter while one is worked on.
// Reset is synchronous; queue contents are undefined until written.
// A stalled result holds the engine once its holding stage and output register are full.
`timescale 1ns / 1ps
module timestamp_ordered_queue_merge import tsqm_pkg::*; #(
   parameter int NUM_QUEUES   = NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [1:0]  req_queue_index,
   input  logic [63:0] req_time_stamp,
   input  logic [63:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [1:0]  rsp_source_queue,
   output logic [63:0] rsp_record_time,
   output logic [63:0] rsp_record_data,
   output logic        rsp_last
);
   logic     item_valid;
   item_type item;
   logic     item_pop;

   tsqm_front #(
      .NUM_QUEUES   (NUM_QUEUES),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_queue_index (req_queue_index),
      .req_time_stamp  (req_time_stamp),
      .req_payload     (req_payload),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   tsqm_engine #(
      .NUM_QUEUES   (NUM_QUEUES),
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .item_pop         (item_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_source_queue (rsp_source_queue),
      .rsp_record_time  (rsp_record_time),
      .rsp_record_data  (rsp_record_data),
      .rsp_last         (rsp_last)
   );
endmodule

// ===== dv/timestamp_ordered_queue_merge_tb.sv =====
// Testbench for the timestamp ordered queue merge: random and directed requests, checked results.
`timescale 1ns / 1ps
module timestamp_ordered_queue_merge_tb;
   import tsqm_pkg::*;

   localparam int NQ = NUM_QUEUES_DEF;
   localparam int DEPTH = QUEUE_DEPTH_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef enum logic {CMD_PUSH = 1'b0, CMD_DRAIN = 1'b1} cmd_type;

   typedef struct {
      cmd_type     cmd;
      logic [1:0]  queue;
      logic [63:0] stamp;
      logic [63:0] data;
   } request_type;

   typedef struct {
      kind_type    kind;
      logic [1:0]  queue;
      logic [63:0] stamp;
      logic [63:0] data;
      logic        last;
   } merge_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_cmd;
   logic [1:0]  req_queue_index;
   logic [63:0] req_time_stamp;
   logic [63:0] req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_kind;
   logic [1:0]  rsp_source_queue;
   logic [63:0] rsp_record_time;
   logic [63:0] rsp_record_data;
   logic        rsp_last;

   timestamp_ordered_queue_merge dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_queue_index(req_queue_index), .req_time_stamp(req_time_stamp),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_source_queue(rsp_source_queue), .rsp_record_time(rsp_record_time),
      .rsp_record_data(rsp_record_data), .rsp_last(rsp_last)
   );

   // Predictor state.
   logic [63:0] stamp_mem [NQ][DEPTH];
   logic [63:0] data_mem [NQ][DEPTH];
   int unsigned head_slot [NQ];
   int unsigned fill [NQ];
   int unsigned pending;
   logic [63:0] release_stamp;

   request_type      pending_requests[$];
   merge_result_type expected_results[$];

   int  sender_idle_pct;
   int  receiver_stall_pct;
   bit  hold_sender;
   bit  stimulus_done;
   int  mismatches;
   int  idle_cycles;

   function automatic merge_result_type make_result(kind_type k, logic [1:0] q,
                                                    logic [63:0] t, logic [63:0] d);
      merge_result_type r;
      r.kind = k;
      r.queue = q;
      r.stamp = t;
      r.data = d;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic predict_merge(request_type req);
      merge_result_type r;
      merge_result_type outs[$];
      logic [63:0] limit;
      logic [63:0] next_stamp;
      logic [63:0] t;
      bit have_next;
      int unsigned had;
      int unsigned q;
      if (req.cmd == CMD_PUSH) begin
         q = req.queue;
         if (q >= NQ || fill[q] >= DEPTH) begin
            r = make_result(KIND_REJECT, req.queue, '0, '0);
         end else begin
            if (fill[q] == 0 && (req.stamp < release_stamp || pending == 0))
               release_stamp = req.stamp;
            stamp_mem[q][(head_slot[q] + fill[q]) % DEPTH] = req.stamp;
            data_mem[q][(head_slot[q] + fill[q]) % DEPTH] = req.data;
            fill[q]++;
            pending++;
            r = make_result(KIND_ACCEPT, req.queue, '0, '0);
         end
         r.last = 1'b1;
         expected_results.push_back(r);
      end else begin
         limit = release_stamp;
         next_stamp = '0;
         have_next = 0;
         for (q = 0; q < NQ; q++) begin
            had = fill[q];
            while (fill[q] > 0) begin
               t = stamp_mem[q][head_slot[q]];
               if (t > limit) begin
                  if (!have_next || t < next_stamp) begin
                     next_stamp = t;
                     have_next = 1;
                  end
                  break;
               end
               outs.push_back(make_result(KIND_RECORD, q[1:0], t, data_mem[q][head_slot[q]]));
               head_slot[q] = (head_slot[q] + 1) % DEPTH;
               fill[q]--;
               if (pending > 0) pending--;
            end
            if (had > 0 && fill[q] == 0)
               outs.push_back(make_result(KIND_EMPTIED, q[1:0], '0, '0));
         end
         if (pending == 0)
            outs.push_back(make_result(KIND_DONE, 2'd0, '0, '0));
         else if (have_next)
            release_stamp = next_stamp;
         if (outs.size() > 0)
            outs[outs.size() - 1].last = 1'b1;
         foreach (outs[i]) expected_results.push_back(outs[i]);
      end
   endtask

   function automatic request_type push_req(logic [1:0] q, logic [63:0] t, logic [63:0] d);
      request_type r;
      r.cmd = CMD_PUSH;
      r.queue = q;
      r.stamp = t;
      r.data = d;
      return r;
   endfunction

   function automatic request_type drain_req();
      request_type r;
      r.cmd = CMD_DRAIN;
      r.queue = 2'($urandom);
      r.stamp = {$urandom, $urandom};
      r.data = {$urandom, $urandom};
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Stamps are mostly small so that drains release several records at once.
   function automatic logic [63:0] rand_stamp();
      case ($urandom_range(0, 9))
         0: return rand64();
         1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
         default: return 64'($urandom_range(0, 60));
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) predict_merge(pending_requests.pop_front());
         if (pending_requests.size() > 0 && !hold_sender &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_cmd <= pending_requests[0].cmd;
            req_queue_index <= pending_requests[0].queue;
            req_time_stamp <= pending_requests[0].stamp;
            req_payload <= pending_requests[0].data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor and receiver stall.
   always @(posedge clock) begin
      merge_result_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result kind=%0d queue=%0d time=%h data=%h last=%b",
                           rsp_kind, rsp_source_queue, rsp_record_time, rsp_record_data,
                           rsp_last);
            end else begin
               e = expected_results.pop_front();
               if (rsp_kind !== e.kind || rsp_source_queue !== e.queue ||
                   rsp_record_time !== e.stamp || rsp_record_data !== e.data ||
                   rsp_last !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected kind=%0d queue=%0d time=%h data=%h last=%b, got kind=%0d queue=%0d time=%h data=%h last=%b",
                              e.kind, e.queue, e.stamp, e.data, e.last, rsp_kind,
                              rsp_source_queue, rsp_record_time, rsp_record_data,
                              rsp_last);
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (stimulus_done && expected_results.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timestamp_ordered_queue_merge test failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
   endtask

   task automatic add_random_items(int count);
      int n;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 30)
            pending_requests.push_back(drain_req());
         else
            pending_requests.push_back(push_req(2'($urandom), rand_stamp(), rand64()));
      end
   endtask

   initial begin
      int i;
      mismatches = 0;
      idle_cycles = 0;
      stimulus_done = 0;
      hold_sender = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      req_valid = 1'b0;
      req_cmd = 1'b0;
      req_queue_index = '0;
      req_time_stamp = '0;
      req_payload = '0;
      rsp_stall = 1'b0;
      release_stamp = '0;
      pending = 0;
      for (i = 0; i < NQ; i++) begin
         head_slot[i] = 0;
         fill[i] = 0;
      end
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: empty drain, extremes, full queue, multi-queue release.
      pending_requests.push_back(drain_req());
      pending_requests.push_back(push_req(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
      pending_requests.push_back(push_req(2'd0, 64'd0, 64'd0));
      pending_requests.push_back(drain_req());
      pending_requests.push_back(drain_req());
      for (i = 0; i < DEPTH + 1; i++)
         pending_requests.push_back(push_req(2'd1, 64'(10 + i), rand64()));
      pending_requests.push_back(push_req(2'd2, 64'd5, 64'hA5A5_5A5A_0F0F_F0F0));
      pending_requests.push_back(push_req(2'd0, 64'd12, 64'h1234_5678_9ABC_DEF0));
      for (i = 0; i < 6; i++) pending_requests.push_back(drain_req());
      wait_drained();

      // Random requests with nothing outstanding; the sender hold is set and cleared with no wait.
      hold_sender = 1;
      add_random_items(10);
      hold_sender = 0;

      for (i = 0; i < 4; i++) begin
         case (i)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
            3: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
         endcase
         add_random_items(65);
         wait_drained();
      end
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      stimulus_done = 1;
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("timestamp_ordered_queue_merge test passed");
      else
         $display("timestamp_ordered_queue_merge test failed");
      $finish;
   end
endmodule
